FILE: hdl/dpa_pkg.sv
package dpa_pkg;

   localparam int WORD_BITS = 32;
   localparam int SHAMT_BITS = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;

   localparam logic [3:0] OP_AND = 4'd0;
   localparam logic [3:0] OP_EOR = 4'd1;
   localparam logic [3:0] OP_SUB = 4'd2;
   localparam logic [3:0] OP_RSB = 4'd3;
   localparam logic [3:0] OP_ADD = 4'd4;
   localparam logic [3:0] OP_TST = 4'd8;
   localparam logic [3:0] OP_TEQ = 4'd9;
   localparam logic [3:0] OP_CMP = 4'd10;
   localparam logic [3:0] OP_ORR = 4'd12;
   localparam logic [3:0] OP_MOV = 4'd13;

   localparam logic [1:0] SH_LSL = 2'd0;
   localparam logic [1:0] SH_LSR = 2'd1;
   localparam logic [1:0] SH_ASR = 2'd2;
   localparam logic [1:0] SH_ROR = 2'd3;

   typedef struct packed {
      logic [3:0]  func;
      logic        immediate_flag;
      logic        set_flags;
      logic [3:0]  dest_index;
      logic [11:0] operand_field;
      word_type    first_value;
      word_type    shifted_value;
      word_type    amount_value;
   } req_type;

   typedef struct packed {
      logic [3:0] func;
      logic       set_flags;
      logic [3:0] dest_index;
      word_type   first_value;
      word_type   operand2;
      logic       shift_carry;
   } opnd_type;

   typedef struct packed {
      word_type   result_value;
      logic       write_enable;
      logic [3:0] write_index;
      logic       flags_write;
      logic       carry_flag;
      logic       bad_opcode;
   } alu_type;

   typedef struct packed {
      word_type   result_value;
      logic       write_enable;
      logic [3:0] write_index;
      logic       flags_write;
      logic       negative_flag;
      logic       zero_flag;
      logic       carry_flag;
      logic       bad_opcode;
   } rsp_type;

   function automatic word_type ror_word(input word_type v, input logic [SHAMT_BITS-1:0] r);
      logic [2*WORD_BITS-1:0] d;
      d = {v, v} >> r;
      return d[WORD_BITS-1:0];
   endfunction

endpackage

FILE: hdl/dpa_shifter.sv
module dpa_shifter (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dpa_pkg::req_type  in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dpa_pkg::opnd_type out_data
);

   localparam int W = dpa_pkg::WORD_BITS;
   localparam int SB = dpa_pkg::SHAMT_BITS;

   logic              valid_ff;
   logic              valid_in;
   dpa_pkg::opnd_type data_ff;
   dpa_pkg::opnd_type data_in;

   logic [7:0]            amt;
   logic [SB-1:0]         amt_lo;
   logic                  amt_small;
   logic                  amt_full;
   logic [1:0]            sh_type;
   dpa_pkg::word_type     v;
   dpa_pkg::word_type     op2;
   logic                  carry;
   logic [W:0]            lsl_w;
   logic [W:0]            lsr_w;
   logic signed [W:0]     asr_w;
   dpa_pkg::word_type     ror_v;
   logic [SB-1:0]         rot;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      v        = in_data.shifted_value;
      sh_type  = in_data.operand_field[6:5];
      amt      = in_data.operand_field[4] ? in_data.amount_value[7:0]
                                          : {3'b000, in_data.operand_field[11:7]};
      amt_lo   = amt[SB-1:0];
      amt_small = (amt[7:SB] == '0);
      amt_full = (amt == 8'(W));
      lsl_w    = {1'b0, v} << amt_lo;
      lsr_w    = {v, 1'b0} >> amt_lo;
      asr_w    = $signed({v, 1'b0}) >>> amt_lo;
      ror_v    = dpa_pkg::ror_word(v, amt_lo);
      rot      = {in_data.operand_field[11:8], 1'b0};
      op2      = v;
      carry    = 1'b0;
      if (in_data.immediate_flag) begin
         op2   = dpa_pkg::ror_word({{(W-8){1'b0}}, in_data.operand_field[7:0]}, rot);
         carry = (rot != '0) ? op2[W-1] : 1'b0;
      end else if (amt != 8'd0) begin
         case (sh_type)
            dpa_pkg::SH_LSL: begin
               if (amt_small) begin
                  op2   = lsl_w[W-1:0];
                  carry = lsl_w[W];
               end else begin
                  op2   = '0;
                  carry = amt_full ? v[0] : 1'b0;
               end
            end
            dpa_pkg::SH_LSR: begin
               if (amt_small) begin
                  op2   = lsr_w[W:1];
                  carry = lsr_w[0];
               end else begin
                  op2   = '0;
                  carry = amt_full ? v[W-1] : 1'b0;
               end
            end
            dpa_pkg::SH_ASR: begin
               if (amt_small) begin
                  op2   = asr_w[W:1];
                  carry = asr_w[0];
               end else begin
                  op2   = {W{v[W-1]}};
                  carry = v[W-1];
               end
            end
            default: begin
               op2   = ror_v;
               carry = ror_v[W-1];
            end
         endcase
      end
   end

   always_comb begin
      data_in             = data_ff;
      valid_in            = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.func        = in_data.func;
            data_in.set_flags   = in_data.set_flags;
            data_in.dest_index  = in_data.dest_index;
            data_in.first_value = in_data.first_value;
            data_in.operand2    = op2;
            data_in.shift_carry = carry;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/dpa_alu.sv
module dpa_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  dpa_pkg::opnd_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output dpa_pkg::alu_type  out_data
);

   localparam int W = dpa_pkg::WORD_BITS;

   logic             valid_ff;
   logic             valid_in;
   dpa_pkg::alu_type data_ff;
   dpa_pkg::alu_type data_in;
   dpa_pkg::alu_type calc;

   logic [W:0] sum_w;
   logic [W:0] sub_w;
   logic [W:0] rsb_w;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      sum_w = {1'b0, in_data.first_value} + {1'b0, in_data.operand2};
      sub_w = {1'b0, in_data.first_value} - {1'b0, in_data.operand2};
      rsb_w = {1'b0, in_data.operand2} - {1'b0, in_data.first_value};
      calc.result_value = '0;
      calc.write_enable = 1'b1;
      calc.write_index  = in_data.dest_index;
      calc.flags_write  = in_data.set_flags;
      calc.carry_flag   = in_data.shift_carry;
      calc.bad_opcode   = 1'b0;
      case (in_data.func)
         dpa_pkg::OP_AND: calc.result_value = in_data.first_value & in_data.operand2;
         dpa_pkg::OP_EOR: calc.result_value = in_data.first_value ^ in_data.operand2;
         dpa_pkg::OP_SUB: begin
            calc.result_value = sub_w[W-1:0];
            calc.carry_flag   = ~sub_w[W];
         end
         dpa_pkg::OP_RSB: begin
            calc.result_value = rsb_w[W-1:0];
            calc.carry_flag   = ~rsb_w[W];
         end
         dpa_pkg::OP_ADD: begin
            calc.result_value = sum_w[W-1:0];
            calc.carry_flag   = sum_w[W];
         end
         dpa_pkg::OP_TST: begin
            calc.result_value = in_data.first_value & in_data.operand2;
            calc.write_enable = 1'b0;
         end
         dpa_pkg::OP_TEQ: begin
            calc.result_value = in_data.first_value ^ in_data.operand2;
            calc.write_enable = 1'b0;
         end
         dpa_pkg::OP_CMP: begin
            calc.result_value = sub_w[W-1:0];
            calc.carry_flag   = ~sub_w[W];
            calc.write_enable = 1'b0;
         end
         dpa_pkg::OP_ORR: calc.result_value = in_data.first_value | in_data.operand2;
         dpa_pkg::OP_MOV: calc.result_value = in_data.operand2;
         default: begin
            calc.write_enable = 1'b0;
            calc.flags_write  = 1'b0;
            calc.carry_flag   = 1'b0;
            calc.bad_opcode   = 1'b1;
         end
      endcase
   end

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in = calc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/dpa_flags.sv
module dpa_flags (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dpa_pkg::alu_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output dpa_pkg::rsp_type out_data
);

   localparam int W = dpa_pkg::WORD_BITS;

   logic             valid_ff;
   logic             valid_in;
   dpa_pkg::rsp_type data_ff;
   dpa_pkg::rsp_type data_in;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      data_in  = data_ff;
      valid_in = valid_ff;
      if (in_ready) begin
         valid_in = in_valid;
         if (in_valid) begin
            data_in.result_value  = in_data.result_value;
            data_in.write_enable  = in_data.write_enable;
            data_in.write_index   = in_data.write_index;
            data_in.flags_write   = in_data.flags_write;
            data_in.negative_flag = in_data.result_value[W-1] & ~in_data.bad_opcode;
            data_in.zero_flag     = (in_data.result_value == '0) & ~in_data.bad_opcode;
            data_in.carry_flag    = in_data.carry_flag;
            data_in.bad_opcode    = in_data.bad_opcode;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

FILE: hdl/data_processing_alu_with_shifter_unit.sv
// Execute unit for one data-processing instruction: operand-2 shifter, ALU, flags.
// Request channel (req_*): opcode, immediate and set-flags bits, destination,
// 12-bit operand-2 field and the Rn, Rm and Rs values, under valid/ready.
// Response channel (rsp_*): result, write enable and index, flag-load strobe,
// N, Z and C, and a bad-opcode mark, under valid/ready.
// Pipeline: shifter stage, ALU stage, flag stage, each registered.
// Throughput: one request per cycle, sustained while rsp_ready stays high.
// The 32-bit add/subtract in the ALU stage and the barrel shifter in the first
// stage set the depth of each stage.
// Reset: all stage valid bits clear; the pipeline comes up empty with
// req_ready high.
// Stall: when rsp_ready is low the response holds; each stage keeps accepting
// while it has a free slot, so up to three requests sit in flight before
// req_ready drops. Nothing is lost or repeated.
module data_processing_alu_with_shifter_unit (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [3:0]                 req_func,
   input  logic                       req_immediate_flag,
   input  logic                       req_set_flags,
   input  logic [3:0]                 req_dest_index,
   input  logic [11:0]                req_operand_field,
   input  logic [dpa_pkg::WORD_BITS-1:0] req_first_value,
   input  logic [dpa_pkg::WORD_BITS-1:0] req_shifted_value,
   input  logic [dpa_pkg::WORD_BITS-1:0] req_amount_value,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [dpa_pkg::WORD_BITS-1:0] rsp_result_value,
   output logic                       rsp_write_enable,
   output logic [3:0]                 rsp_write_index,
   output logic                       rsp_flags_write,
   output logic                       rsp_negative_flag,
   output logic                       rsp_zero_flag,
   output logic                       rsp_carry_flag,
   output logic                       rsp_bad_opcode
);

   dpa_pkg::req_type  req_data;
   dpa_pkg::opnd_type opnd_data;
   dpa_pkg::alu_type  alu_data;
   dpa_pkg::rsp_type  rsp_data;
   logic              opnd_valid;
   logic              opnd_ready;
   logic              alu_valid;
   logic              alu_ready;

   always_comb begin
      req_data.func           = req_func;
      req_data.immediate_flag = req_immediate_flag;
      req_data.set_flags      = req_set_flags;
      req_data.dest_index     = req_dest_index;
      req_data.operand_field  = req_operand_field;
      req_data.first_value    = req_first_value;
      req_data.shifted_value  = req_shifted_value;
      req_data.amount_value   = req_amount_value;
   end

   dpa_shifter u_shifter (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (opnd_valid),
      .out_ready (opnd_ready),
      .out_data  (opnd_data)
   );

   dpa_alu u_alu (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (opnd_valid),
      .in_ready  (opnd_ready),
      .in_data   (opnd_data),
      .out_valid (alu_valid),
      .out_ready (alu_ready),
      .out_data  (alu_data)
   );

   dpa_flags u_flags (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (alu_valid),
      .in_ready  (alu_ready),
      .in_data   (alu_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_result_value  = rsp_data.result_value;
   assign rsp_write_enable  = rsp_data.write_enable;
   assign rsp_write_index   = rsp_data.write_index;
   assign rsp_flags_write   = rsp_data.flags_write;
   assign rsp_negative_flag = rsp_data.negative_flag;
   assign rsp_zero_flag     = rsp_data.zero_flag;
   assign rsp_carry_flag    = rsp_data.carry_flag;
   assign rsp_bad_opcode    = rsp_data.bad_opcode;

endmodule
